// ===== hw/rtl/sust_pkg.sv =====
// sust_pkg: shared field widths, function and status codes and the sequencer state type
// for the sorted unique set table; no dependencies, compiled first
package sust_pkg;

  localparam int FUNC_W   = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  // function codes carried in the request
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_TEST   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RANK   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

  // status codes returned in the response
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SEARCH,
    ST_RANK,
    ST_UP,
    ST_PUT,
    ST_DOWN,
    ST_RESP
  } state_e;

endpackage

// ===== hw/rtl/sust_req_if.sv =====
// sust_req_if: request channel of the sorted unique set table (valid, ready, payload)
// depends on sust_pkg for field widths
interface sust_req_if;
  logic                                  valid;
  logic                                  ready;
  logic        [sust_pkg::FUNC_W-1:0]    func;
  logic signed [sust_pkg::DATA_W-1:0]    value;
  logic        [sust_pkg::POS_W-1:0]     position;

  modport source (output valid, output func, output value, output position, input ready);
  modport sink   (input valid, input func, input value, input position, output ready);
endinterface

// ===== hw/rtl/sust_rsp_if.sv =====
// sust_rsp_if: response channel of the sorted unique set table (valid, ready, payload)
// depends on sust_pkg for field widths
interface sust_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  hit;
  logic signed [sust_pkg::DATA_W-1:0]    item;
  logic        [sust_pkg::COUNT_W-1:0]   count;
  logic        [sust_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output hit, output item, output count, output status,
                  input ready);
  modport sink   (input valid, input hit, input item, input count, input status,
                  output ready);
endinterface

// ===== hw/rtl/sust_store.sv =====
// sust_store: value memory of the set table, one write and one read port,
// read data registered; depends on sust_pkg for the data width
module sust_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [sust_pkg::DATA_W-1:0]   wdata_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [sust_pkg::DATA_W-1:0]   rdata_o
);

  logic [sust_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [sust_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sorted_unique_set_table.sv =====
// sorted_unique_set_table: bounded set of unique signed 32-bit values kept in ascending
// order in one memory; depends on sust_pkg, sust_req_if, sust_rsp_if and sust_store
//
// usage
// - req_i carries func, value and position; a transfer happens when valid and ready are
//   both high. ready is high only while the sequencer is idle, so one request is in work
//   at a time
// - rsp_o carries hit, item, count and status from an output register; a finished result
//   may wait there while the next request is already taken and worked on
// - add, remove and test scan the memory from rank 0, one entry per cycle, to the first
//   entry not below the value (lower bound); add then moves the tail up one entry per
//   cycle and writes the new value, remove moves the tail down one entry per cycle
// - clear, unused codes and rank reads finish without a scan; for test, remove and add the
//   time to the response grows with the stored count, since scan and tail move both go
//   through the single memory read port
// - the memory is not cleared: only entries below the count are used, so reset just
//   zeroes count, sequencer and output valid; the block takes requests right after reset
// - if the receiver stalls, the finished result waits in the sequencer until the output
//   register is free; nothing is dropped and no further request is taken meanwhile
module sorted_unique_set_table #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sust_req_if.sink    req_i,
  sust_rsp_if.source  rsp_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > sust_pkg::POS_W) ? CW : sust_pkg::POS_W;

  sust_pkg::state_e state_q, state_d;
  sust_pkg::state_e after_search;

  // latched request
  logic [sust_pkg::FUNC_W-1:0] func_q;
  logic [sust_pkg::DATA_W-1:0] value_q;
  logic [sust_pkg::POS_W-1:0]  pos_q;

  // scan pointer, found rank and stored count
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;

  // staged result
  logic                          hit_q, hit_d;
  logic [sust_pkg::DATA_W-1:0]   item_q, item_d;
  logic [sust_pkg::STATUS_W-1:0] status_q, status_d;

  // output register
  logic                          out_valid_q;
  logic                          out_hit_q;
  logic [sust_pkg::DATA_W-1:0]   out_item_q;
  logic [sust_pkg::COUNT_W-1:0]  out_count_q;
  logic [sust_pkg::STATUS_W-1:0] out_status_q;
  logic                          out_load;

  // memory port
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [sust_pkg::DATA_W-1:0] mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [sust_pkg::DATA_W-1:0] mem_rdata;

  logic          req_xfer;
  logic [CW-1:0] ptr_inc, ptr_dec, cnt_dec;
  logic [PW-1:0] pos_w, cnt_w;
  logic          full;
  logic          srch_ge, srch_done, srch_pres;
  logic [CW-1:0] srch_idx;

  sust_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign req_i.ready = (state_q == sust_pkg::ST_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;

  assign ptr_inc = ptr_q + CW'(1);
  assign ptr_dec = ptr_q - CW'(1);
  assign cnt_dec = count_q - CW'(1);
  assign pos_w   = PW'(pos_q);
  assign cnt_w   = PW'(count_q);
  assign full    = (count_q == CW'(CAPACITY));

  // lower bound scan: rd data holds the entry at ptr_q while searching
  assign srch_ge   = (state_q == sust_pkg::ST_SEARCH) &&
                     ($signed(mem_rdata) >= $signed(value_q));
  assign srch_pres = srch_ge && (mem_rdata == value_q);
  assign srch_idx  = srch_ge ? ptr_q : count_q;
  assign srch_done = ((state_q == sust_pkg::ST_START) && (count_q == '0)) ||
                     ((state_q == sust_pkg::ST_SEARCH) && (srch_ge || (ptr_inc == count_q)));

  // where a finished search leads
  always_comb begin
    case (func_q)
      sust_pkg::FUNC_ADD: begin
        if (srch_pres || full) begin
          after_search = sust_pkg::ST_RESP;
        end else if (srch_idx == count_q) begin
          after_search = sust_pkg::ST_PUT;
        end else begin
          after_search = sust_pkg::ST_UP;
        end
      end
      sust_pkg::FUNC_REMOVE: begin
        if (!srch_pres || ((srch_idx + CW'(1)) == count_q)) begin
          after_search = sust_pkg::ST_RESP;
        end else begin
          after_search = sust_pkg::ST_DOWN;
        end
      end
      default: after_search = sust_pkg::ST_RESP;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sust_pkg::ST_IDLE: begin
        if (req_xfer) state_d = sust_pkg::ST_START;
      end
      sust_pkg::ST_START: begin
        case (func_q)
          sust_pkg::FUNC_ADD, sust_pkg::FUNC_REMOVE, sust_pkg::FUNC_TEST: begin
            state_d = (count_q == '0) ? after_search : sust_pkg::ST_SEARCH;
          end
          sust_pkg::FUNC_RANK: begin
            state_d = (pos_w < cnt_w) ? sust_pkg::ST_RANK : sust_pkg::ST_RESP;
          end
          default: state_d = sust_pkg::ST_RESP;
        endcase
      end
      sust_pkg::ST_SEARCH: begin
        if (srch_done) state_d = after_search;
      end
      sust_pkg::ST_RANK: state_d = sust_pkg::ST_RESP;
      sust_pkg::ST_UP: begin
        if (ptr_q == idx_q) state_d = sust_pkg::ST_PUT;
      end
      sust_pkg::ST_PUT: state_d = sust_pkg::ST_RESP;
      sust_pkg::ST_DOWN: begin
        if (ptr_inc == count_q) state_d = sust_pkg::ST_RESP;
      end
      sust_pkg::ST_RESP: begin
        if (out_load) state_d = sust_pkg::ST_IDLE;
      end
      default: state_d = sust_pkg::ST_IDLE;
    endcase
  end

  // memory port, pointers, count and result staging
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_q[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    ptr_d     = ptr_q;
    idx_d     = idx_q;
    count_d   = count_q;
    hit_d     = hit_q;
    item_d    = item_q;
    status_d  = status_q;
    out_load  = 1'b0;

    case (state_q)
      sust_pkg::ST_START: begin
        hit_d    = 1'b0;
        item_d   = '0;
        status_d = sust_pkg::STATUS_OK;
        case (func_q)
          sust_pkg::FUNC_CLEAR: count_d = '0;
          sust_pkg::FUNC_RANK: begin
            if (pos_w < cnt_w) begin
              mem_raddr = pos_w[AW-1:0];
            end else begin
              status_d = sust_pkg::STATUS_RANGE;
            end
          end
          sust_pkg::FUNC_ADD, sust_pkg::FUNC_REMOVE, sust_pkg::FUNC_TEST: begin
            if (count_q != '0) begin
              // first scan read at rank 0
              mem_raddr = '0;
              ptr_d     = '0;
            end else begin
              // empty table: nothing present, insert point is rank 0
              idx_d = '0;
            end
          end
          default: ;
        endcase
      end
      sust_pkg::ST_SEARCH: begin
        if (srch_done) begin
          idx_d = srch_idx;
          case (func_q)
            sust_pkg::FUNC_TEST: hit_d = srch_pres;
            sust_pkg::FUNC_ADD: begin
              if (!srch_pres && full) begin
                status_d = sust_pkg::STATUS_FULL;
              end else if (!srch_pres && (srch_idx != count_q)) begin
                // start moving the tail up from the top entry
                mem_raddr = cnt_dec[AW-1:0];
                ptr_d     = cnt_dec;
              end
            end
            sust_pkg::FUNC_REMOVE: begin
              if (srch_pres) begin
                if ((srch_idx + CW'(1)) == count_q) begin
                  // removed the top entry, no move needed
                  count_d = cnt_dec;
                  hit_d   = 1'b1;
                end else begin
                  mem_raddr = ptr_inc[AW-1:0];
                  ptr_d     = ptr_inc;
                end
              end
            end
            default: ;
          endcase
        end else begin
          mem_raddr = ptr_inc[AW-1:0];
          ptr_d     = ptr_inc;
        end
      end
      sust_pkg::ST_RANK: begin
        item_d = mem_rdata;
        hit_d  = 1'b1;
      end
      sust_pkg::ST_UP: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_inc[AW-1:0];
        if (ptr_q != idx_q) begin
          mem_raddr = ptr_dec[AW-1:0];
          ptr_d     = ptr_dec;
        end
      end
      sust_pkg::ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        mem_wdata = value_q;
        count_d   = count_q + CW'(1);
        hit_d     = 1'b1;
      end
      sust_pkg::ST_DOWN: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_dec[AW-1:0];
        if (ptr_inc == count_q) begin
          count_d = cnt_dec;
          hit_d   = 1'b1;
        end else begin
          mem_raddr = ptr_inc[AW-1:0];
          ptr_d     = ptr_inc;
        end
      end
      sust_pkg::ST_RESP: out_load = !out_valid_q || rsp_o.ready;
      default: ;
    endcase

    // empty-table remove/test completes straight from the start state, test with no hit
    if ((state_q == sust_pkg::ST_START) && srch_done && (func_q == sust_pkg::FUNC_TEST)) begin
      hit_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sust_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      func_q  <= req_i.func;
      value_q <= req_i.value;
      pos_q   <= req_i.position;
    end
    ptr_q    <= ptr_d;
    idx_q    <= idx_d;
    hit_q    <= hit_d;
    item_q   <= item_d;
    status_q <= status_d;
    if (out_load) begin
      out_hit_q    <= hit_q;
      out_item_q   <= item_q;
      out_count_q  <= sust_pkg::COUNT_W'(count_q);
      out_status_q <= status_q;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.hit    = out_hit_q;
  assign rsp_o.item   = out_item_q;
  assign rsp_o.count  = out_count_q;
  assign rsp_o.status = out_status_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("stored count above capacity");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == sust_pkg::ST_UP || state_q == sust_pkg::ST_PUT ||
                state_q == sust_pkg::ST_DOWN))
    else $error("memory written outside a move or insert");

  a_put_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sust_pkg::ST_PUT) |=> (count_q == CW'($past(count_q) + CW'(1))))
    else $error("insert did not grow the count by one");

  a_resp_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && state_q == sust_pkg::ST_IDLE))
    else $error("finished result not presented");
`endif

endmodule
